// ===== hw/rtl/wgm_pkg.sv =====
// Package for the wildcard glob matcher: sizes, byte codes, operation codes and item types.
package wgm_pkg;

   localparam int MAX_PATTERN = 32;
   localparam int ROW_W       = MAX_PATTERN + 1;
   localparam int CNT_W       = $clog2(MAX_PATTERN + 1);
   localparam int IDX_W       = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

   localparam logic [7:0] STAR_CHAR  = 8'h2A;
   localparam logic [7:0] QMARK_CHAR = 8'h3F;

   typedef enum logic [1:0] {
      OP_APPEND = 2'd0,
      OP_TEXT   = 2'd1,
      OP_FINISH = 2'd2,
      OP_CLEAR  = 2'd3
   } op_type;

   typedef struct packed {
      op_type     operation;
      logic [7:0] character;
   } req_type;

   typedef struct packed {
      logic matched;
      logic pattern_overflow;
   } rsp_type;

endpackage

// ===== hw/rtl/wildcard_glob_matcher.sv =====
// Wildcard glob matcher: pattern store, bit-parallel match row and result register.
//
//   channel | direction | ports                          | item
//   req     | in        | req_valid, req_stall, req_data | operation, character
//   rsp     | out       | rsp_valid, rsp_stall, rsp_data | matched, pattern_overflow
//
// Each accepted text character updates the match row by a single carry-chain
// add over the pattern positions, and the result is in the output register on
// the next cycle. One item per cycle is sustained while the output is not stalled.
// Synchronous reset empties the pattern and the output register.
// The input stalls only while a result waits and the output is stalled.
module wildcard_glob_matcher (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  wgm_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output wgm_pkg::rsp_type rsp_data
);
   import wgm_pkg::*;

   logic [7:0]       pattern_ff [MAX_PATTERN];
   logic [CNT_W-1:0] count_ff, count_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [ROW_W-1:0] start_ff, start_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff, rsp_data_in;

   logic             accept;
   logic             room;
   logic             in_star;
   logic [ROW_W-1:0] gen, prop, start_app, text_row;
   logic [ROW_W:0]   chain_x, chain_g, chain_sum, chain_cin;

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;
   assign room      = count_ff < CNT_W'(MAX_PATTERN);
   assign in_star   = req_data.character == STAR_CHAR;

   // A star position propagates the new bit below it and generates from its
   // own old bit; other positions only generate. The add resolves the chain.
   always_comb begin
      gen  = '0;
      prop = '0;
      for (int j = 1; j <= MAX_PATTERN; j++) begin
         if (CNT_W'(j) <= count_ff) begin
            if (pattern_ff[j-1] == STAR_CHAR) begin
               prop[j] = 1'b1;
               gen[j]  = row_ff[j];
            end else begin
               gen[j] = row_ff[j-1] &
                        ((pattern_ff[j-1] == req_data.character) |
                         (pattern_ff[j-1] == QMARK_CHAR));
            end
         end
      end
   end

   assign chain_x   = {1'b0, gen | prop};
   assign chain_g   = {1'b0, gen};
   assign chain_sum = chain_x + chain_g;
   assign chain_cin = chain_sum ^ chain_x ^ chain_g;
   assign text_row  = chain_cin[ROW_W:1];

   // The start row grows by one bit when a star extends the leading star run.
   always_comb begin
      start_app = start_ff;
      for (int j = 1; j <= MAX_PATTERN; j++) begin
         if (CNT_W'(j - 1) == count_ff) begin
            start_app[j] = start_ff[j-1] & in_star;
         end
      end
   end

   always_comb begin
      count_in    = count_ff;
      row_in      = row_ff;
      start_in    = start_ff;
      rsp_data_in = rsp_data_ff;
      if (accept) begin
         rsp_data_in.pattern_overflow = 1'b0;
         case (req_data.operation)
            OP_APPEND: begin
               if (room) begin
                  count_in = count_ff + CNT_W'(1);
                  start_in = start_app;
                  row_in   = start_app;
               end else begin
                  rsp_data_in.pattern_overflow = 1'b1;
               end
            end
            OP_TEXT: begin
               row_in = text_row;
            end
            OP_FINISH: begin
               row_in = start_ff;
            end
            OP_CLEAR: begin
               count_in = '0;
               start_in = ROW_W'(1);
               row_in   = ROW_W'(1);
            end
            default: begin
               row_in = row_ff;
            end
         endcase
         if (req_data.operation == OP_FINISH) begin
            rsp_data_in.matched = row_ff[count_ff];
         end else begin
            rsp_data_in.matched = row_in[count_in];
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (~rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         row_ff       <= ROW_W'(1);
         start_ff     <= ROW_W'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         row_ff       <= row_in;
         start_ff     <= start_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      if (accept && req_data.operation == OP_APPEND && room) begin
         pattern_ff[count_ff[IDX_W-1:0]] <= req_data.character;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== hw/rtl/wgm_checker.sv =====
// Port-level checker for the wildcard glob matcher and its bind statement.
module wgm_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input wgm_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input wgm_pkg::rsp_type rsp_data
);
   import wgm_pkg::*;

   logic req_take;
   assign req_take = req_valid & ~req_stall;

   // Every accepted item has its result waiting on the next cycle.
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      req_take |=> rsp_valid)
      else $error("accepted item produced no result");

   // A cleared pattern always matches the empty text.
   a_clear_matches: assert property (@(posedge clock) disable iff (reset)
      req_take && req_data.operation == OP_CLEAR |=>
         rsp_data.matched && !rsp_data.pattern_overflow)
      else $error("clear item did not report a match");

   // Only an append can be dropped for lack of room.
   a_overflow_append_only: assert property (@(posedge clock) disable iff (reset)
      req_take && req_data.operation != OP_APPEND |=> !rsp_data.pattern_overflow)
      else $error("overflow flagged on a non-append item");

   a_rsp_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed or vanished");

endmodule

bind wildcard_glob_matcher wgm_checker u_wgm_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
